// ----- sv/ssrq_pkg.sv -----
`default_nettype none

package ssrq_pkg;

  // Capacity of the set and width of one stored value
  localparam int unsigned DEPTH      = 1024;
  localparam int unsigned VALUE_BITS = 30;

  // Internal rank counter holds 0..DEPTH; the reported count is fixed at 11 bits
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned COUNT_BITS = 11;
  localparam int unsigned OP_BITS    = 2;

  // Request opcodes; the unused code travels down the chain as an empty slot
  typedef enum logic [OP_BITS-1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // One slot moving down the cell chain
  typedef struct packed {
    op_e                   op;
    logic [VALUE_BITS-1:0] value;
    logic [CNT_W-1:0]      cnt;
    logic                  ovf;
  } tok_t;

endpackage

`default_nettype wire

// ----- sv/ssrq_if.sv -----
`default_nettype none

// Request channel: operation and value
interface ssrq_req_if;
  logic                           valid;
  logic                           ready;
  logic [ssrq_pkg::OP_BITS-1:0]   operation;
  logic [ssrq_pkg::VALUE_BITS-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

// Result channel: rank count and sticky overflow flag
interface ssrq_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [ssrq_pkg::COUNT_BITS-1:0] count;
  logic                            overflowed;

  modport source (output valid, output count, output overflowed, input ready);
  modport sink   (input valid, input count, input overflowed, output ready);
endinterface

`default_nettype wire

// ----- sv/ssrq_cell.sv -----
`default_nettype none

module ssrq_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           adv_i,
  input  wire ssrq_pkg::tok_t tok_i,
  output ssrq_pkg::tok_t      tok_o
);

  logic                             valid_q, valid_d;
  logic [ssrq_pkg::VALUE_BITS-1:0]  val_q, val_d;
  ssrq_pkg::tok_t                   tok_d;
  ssrq_pkg::op_e                    op_q;
  logic [ssrq_pkg::VALUE_BITS-1:0]  value_q;
  logic [ssrq_pkg::CNT_W-1:0]       cnt_q;
  logic                             ovf_q;

  // Update the held value and build the slot for the next cell
  always_comb begin
    valid_d = valid_q;
    val_d   = val_q;
    tok_d   = tok_i;
    case (tok_i.op)
      ssrq_pkg::OP_LOAD: begin
        if (!valid_q) begin
          // take the value here and end the insert
          valid_d  = 1'b1;
          val_d    = tok_i.value;
          tok_d.op = ssrq_pkg::OP_NONE;
        end else if (tok_i.value < val_q) begin
          // keep the smaller value, push the held one onward
          val_d       = tok_i.value;
          tok_d.value = val_q;
        end
      end
      ssrq_pkg::OP_QUERY: begin
        tok_d.cnt = tok_i.cnt + ssrq_pkg::CNT_W'(valid_q && (val_q <= tok_i.value));
      end
      ssrq_pkg::OP_CLEAR: begin
        valid_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Hold control state under reset, advance with the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      op_q    <= ssrq_pkg::OP_NONE;
    end else if (adv_i) begin
      valid_q <= valid_d;
      op_q    <= tok_d.op;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      val_q   <= val_d;
      value_q <= tok_d.value;
      cnt_q   <= tok_d.cnt;
      ovf_q   <= tok_d.ovf;
    end
  end

  assign tok_o = '{op: op_q, value: value_q, cnt: cnt_q, ovf: ovf_q};

endmodule

`default_nettype wire

// ----- sv/sorted_set_rank_query.sv -----
`default_nettype none

// Channel  Dir  Role    Payload
// req_i    in   sink    operation (0 load, 1 query, 2 clear), value
// rsp_o    out  source  count, overflowed (one per query)
//
// Unless stalled, one request enters per cycle; each walks DEPTH cells, one a cycle.
// A query result passes the DEPTH cell registers and then the result register.
// Reset empties the set and clears the overflow flag; no clearing pass is needed.
// A stalled result freezes the whole chain, and req_i.ready drops for that cycle.
module sorted_set_rank_query (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ssrq_req_if.sink   req_i,
  ssrq_rsp_if.source rsp_o
);

  logic                         adv;
  logic                         acc;
  logic [ssrq_pkg::CNT_W-1:0]   count_q, count_d;
  logic                         ovf_q, ovf_d;
  ssrq_pkg::tok_t               head;
  ssrq_pkg::tok_t               chain [ssrq_pkg::DEPTH+1];
  logic                         rsp_valid_q;
  logic [ssrq_pkg::COUNT_BITS-1:0] rsp_count_q;
  logic                         rsp_ovf_q;

  // Advance the chain whenever the result register can take the tail slot
  assign adv         = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = adv;
  assign acc         = req_i.valid && adv;

  // Build the head slot and track fill level and overflow
  always_comb begin
    count_d    = count_q;
    ovf_d      = ovf_q;
    head.op    = ssrq_pkg::OP_NONE;
    head.value = req_i.value;
    head.cnt   = '0;
    head.ovf   = ovf_q;
    if (acc) begin
      case (ssrq_pkg::op_e'(req_i.operation))
        ssrq_pkg::OP_LOAD: begin
          if (count_q == ssrq_pkg::CNT_W'(ssrq_pkg::DEPTH)) begin
            // drop the load into a full set
            ovf_d = 1'b1;
          end else begin
            head.op = ssrq_pkg::OP_LOAD;
            count_d = count_q + ssrq_pkg::CNT_W'(1);
          end
        end
        ssrq_pkg::OP_QUERY: begin
          head.op = ssrq_pkg::OP_QUERY;
        end
        ssrq_pkg::OP_CLEAR: begin
          head.op = ssrq_pkg::OP_CLEAR;
          count_d = '0;
          ovf_d   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  assign chain[0] = head;

  // Row of cells, each holding one sorted entry
  for (genvar g = 0; g < ssrq_pkg::DEPTH; g++) begin : g_cell
    ssrq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tok_i  (chain[g]),
      .tok_o  (chain[g+1])
    );
  end

  // Capture queries leaving the tail
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (adv) begin
      rsp_valid_q <= (chain[ssrq_pkg::DEPTH].op == ssrq_pkg::OP_QUERY);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rsp_count_q <= ssrq_pkg::COUNT_BITS'(chain[ssrq_pkg::DEPTH].cnt);
      rsp_ovf_q   <= chain[ssrq_pkg::DEPTH].ovf;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.count      = rsp_count_q;
  assign rsp_o.overflowed = rsp_ovf_q;

endmodule

`default_nettype wire
